// ===== sv/pixel_to_rgb8_converter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel to RGB8 converter
// Immediate-implication and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_RGB8_CONVERTER_ASSERT_SVH
`define PIXEL_TO_RGB8_CONVERTER_ASSERT_SVH

// ante true at an edge -> cons true at the same edge
`define P2R8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipeline check failed");

// ante true at an edge -> cons true at the next edge
`define P2R8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipeline check failed");

`endif

// ===== sv/p2r8_pkg.sv =====
// ----------------------------------------------------------------------------
// p2r8_pkg
// Shared types and constants for the pixel to RGB8 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package p2r8_pkg;

  // channel encoding, low two bits of source_format (alpha bit ignored)
  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_U16 = 2'd1,
    FMT_F16 = 2'd2,
    FMT_F32 = 2'd3
  } fmt_kind_t;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  localparam int unsigned RAW_W = 32;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned SIG_W = 24;          // f32 significand incl. hidden bit
  localparam int unsigned EXP_W = 9;           // signed exponent, -149..104
  localparam int unsigned PROD_W = SIG_W + 8;  // sig * 255

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

  // value = sig * 2^ex ; ex offsets include the significand scaling
  localparam logic [EXP_W-1:0] F16_EXP_OFS = 9'd25;
  localparam logic [EXP_W-1:0] F16_SUB_EXP = 9'h1E8;  // -24
  localparam logic [EXP_W-1:0] F32_EXP_OFS = 9'd150;
  localparam logic [EXP_W-1:0] F32_SUB_EXP = 9'h16B;  // -149

endpackage

`default_nettype wire

// ===== sv/p2r8_channel.sv =====
// ----------------------------------------------------------------------------
// p2r8_channel
// Three-stage datapath for one channel: decode, scale by 255, shift/saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module p2r8_channel (
  input  logic                                clk,
  input  p2r8_pkg::stage_en_t                 en,
  input  p2r8_pkg::fmt_kind_t                 kind,
  input  logic [p2r8_pkg::RAW_W-1:0]          raw,
  output logic [p2r8_pkg::PIX_W-1:0]          pix
);

  // stage 1 decode results
  logic                          direct_c;
  logic [p2r8_pkg::PIX_W-1:0]    dval_c;
  logic [p2r8_pkg::SIG_W-1:0]    sig_c;
  logic [p2r8_pkg::EXP_W-1:0]    ex_c;

  logic                          d1_direct;
  logic [p2r8_pkg::PIX_W-1:0]    d1_dval;
  logic [p2r8_pkg::SIG_W-1:0]    d1_sig;
  logic [p2r8_pkg::EXP_W-1:0]    d1_ex;

  logic                          d2_direct;
  logic [p2r8_pkg::PIX_W-1:0]    d2_dval;
  logic [p2r8_pkg::PROD_W-1:0]   d2_prod;
  logic [p2r8_pkg::EXP_W-1:0]    d2_ex;

  logic [p2r8_pkg::PIX_W-1:0]    pix_next;

  // ---------------- stage 1: decode ----------------
  always_comb begin
    direct_c = 1'b0;
    dval_c   = p2r8_pkg::PIX_ZERO;
    sig_c    = '0;
    ex_c     = '0;
    unique case (kind)
      p2r8_pkg::FMT_U8: begin
        direct_c = 1'b1;
        dval_c   = raw[7:0];
      end
      p2r8_pkg::FMT_U16: begin
        direct_c = 1'b1;
        dval_c   = raw[15:8];
      end
      p2r8_pkg::FMT_F16: begin
        if (raw[14:10] == 5'h1F) begin
          // inf or NaN: only +inf saturates
          direct_c = 1'b1;
          dval_c   = (raw[9:0] != 10'd0 || raw[15]) ? p2r8_pkg::PIX_ZERO
                                                     : p2r8_pkg::PIX_MAX;
        end else if (raw[15]) begin
          direct_c = 1'b1;
        end else if (raw[14:10] == 5'd0) begin
          sig_c = {14'd0, raw[9:0]};
          ex_c  = p2r8_pkg::F16_SUB_EXP;
        end else begin
          sig_c = {13'd0, 1'b1, raw[9:0]};
          ex_c  = {4'd0, raw[14:10]} - p2r8_pkg::F16_EXP_OFS;
        end
      end
      p2r8_pkg::FMT_F32: begin
        if (raw[30:23] == 8'hFF) begin
          direct_c = 1'b1;
          dval_c   = (raw[22:0] != 23'd0 || raw[31]) ? p2r8_pkg::PIX_ZERO
                                                      : p2r8_pkg::PIX_MAX;
        end else if (raw[31]) begin
          direct_c = 1'b1;
        end else if (raw[30:23] == 8'd0) begin
          sig_c = {1'b0, raw[22:0]};
          ex_c  = p2r8_pkg::F32_SUB_EXP;
        end else begin
          sig_c = {1'b1, raw[22:0]};
          ex_c  = {1'b0, raw[30:23]} - p2r8_pkg::F32_EXP_OFS;
        end
      end
      default: begin
        direct_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d1_direct <= direct_c;
      d1_dval   <= dval_c;
      d1_sig    <= sig_c;
      d1_ex     <= ex_c;
    end
  end

  // ---------------- stage 2: sig * 255 ----------------
  always_ff @(posedge clk) begin
    if (en.s2) begin
      d2_direct <= d1_direct;
      d2_dval   <= d1_dval;
      d2_prod   <= {d1_sig, 8'h00} - {8'h00, d1_sig};
      d2_ex     <= d1_ex;
    end
  end

  // ---------------- stage 3: scale by 2^ex, saturate ----------------
  always_comb begin
    logic [p2r8_pkg::PROD_W+7:0] lsh;
    logic [p2r8_pkg::EXP_W-1:0]  rsh_amt;
    logic [p2r8_pkg::PROD_W-1:0] rsh;
    lsh      = {8'h00, d2_prod} << d2_ex[2:0];
    rsh_amt  = ~d2_ex + 9'd1;
    rsh      = d2_prod >> rsh_amt[4:0];
    pix_next = p2r8_pkg::PIX_ZERO;
    if (d2_direct) begin
      pix_next = d2_dval;
    end else if (d2_prod == '0) begin
      pix_next = p2r8_pkg::PIX_ZERO;
    end else if (!d2_ex[p2r8_pkg::EXP_W-1]) begin
      if (|d2_ex[7:3] || |lsh[p2r8_pkg::PROD_W+7:8]) begin
        pix_next = p2r8_pkg::PIX_MAX;
      end else begin
        pix_next = lsh[7:0];
      end
    end else if (|rsh_amt[8:5]) begin
      // shifted past every product bit
      pix_next = p2r8_pkg::PIX_ZERO;
    end else if (|rsh[p2r8_pkg::PROD_W-1:8]) begin
      pix_next = p2r8_pkg::PIX_MAX;
    end else begin
      pix_next = rsh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pix <= pix_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pixel_to_rgb8_converter.sv =====
// Pipeline: an accepted input is registered in the decode, x255 and shift
//   stages in that order; out_valid rises when it reaches the shift stage.
// Throughput: one item per cycle unless out_ready stalls; each channel has its
//   own datapath, so the three-stage pipeline sets the rate; a stall holds the
//   full stages in place while empty stages still load, so bubbles close up.
// Reset: rst (synchronous) empties the pipeline and sets source_format to 0.
// ----------------------------------------------------------------------------
// pixel_to_rgb8_converter
// Converts u8/u16/f16/f32 RGB(A) pixels to 8-bit RGB, alpha dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_to_rgb8_converter_assert.svh"

module pixel_to_rgb8_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [p2r8_pkg::RAW_W-1:0] red_in,
  input  logic [p2r8_pkg::RAW_W-1:0] green_in,
  input  logic [p2r8_pkg::RAW_W-1:0] blue_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [p2r8_pkg::PIX_W-1:0] red_out,
  output logic [p2r8_pkg::PIX_W-1:0] green_out,
  output logic [p2r8_pkg::PIX_W-1:0] blue_out
);

  logic [2:0]          source_format;
  logic                v1;
  logic                v2;
  logic                v3;
  p2r8_pkg::stage_en_t en;
  p2r8_pkg::fmt_kind_t kind;

  // rgba formats convert as their rgb counterparts
  assign kind = p2r8_pkg::fmt_kind_t'(source_format[1:0]);

  // a stage loads when it is empty or its contents move on
  assign en.s3    = !v3 || out_ready;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign in_ready = en.s1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= 3'd0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
    end else begin
      if (cfg_we) begin
        source_format <= cfg_data;
      end
      if (en.s1) begin
        v1 <= in_valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
    end
  end

  p2r8_channel u_red (
    .clk  (clk),
    .en   (en),
    .kind (kind),
    .raw  (red_in),
    .pix  (red_out)
  );

  p2r8_channel u_green (
    .clk  (clk),
    .en   (en),
    .kind (kind),
    .raw  (green_in),
    .pix  (green_out)
  );

  p2r8_channel u_blue (
    .clk  (clk),
    .en   (en),
    .kind (kind),
    .raw  (blue_in),
    .pix  (blue_out)
  );

  `P2R8_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1)
  `P2R8_ASSERT_NEXT(a_s1_held_on_stall, v1 && !en.s2, v1)
  `P2R8_ASSERT_NOW(a_full_blocks_input, v1 && v2 && v3 && !out_ready, !in_ready)

endmodule

`default_nettype wire

// ===== bench/tb_pixel_to_rgb8_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_to_rgb8_converter
// Streams raw RGB(A) pixels through the converter under every source format,
// predicts each 8-bit RGB result in the bench and checks every output item
// in order, with random idle bursts on both handshakes and one long sink hold.
// ----------------------------------------------------------------------------
module tb_pixel_to_rgb8_converter;

  typedef enum logic [2:0] {
    SRC_RGB_U8   = 3'd0,
    SRC_RGB_U16  = 3'd1,
    SRC_RGB_F16  = 3'd2,
    SRC_RGB_F32  = 3'd3,
    SRC_RGBA_U8  = 3'd4,
    SRC_RGBA_U16 = 3'd5,
    SRC_RGBA_F16 = 3'd6,
    SRC_RGBA_F32 = 3'd7
  } src_fmt_t;

  typedef struct packed {
    logic [p2r8_pkg::RAW_W-1:0] r;
    logic [p2r8_pkg::RAW_W-1:0] g;
    logic [p2r8_pkg::RAW_W-1:0] b;
  } src_pixel_t;

  typedef struct packed {
    logic [p2r8_pkg::PIX_W-1:0] r;
    logic [p2r8_pkg::PIX_W-1:0] g;
    logic [p2r8_pkg::PIX_W-1:0] b;
  } rgb8_t;

  localparam int NUM_PHASES     = 13;
  localparam int HOLD_PHASE     = 4;
  localparam int RAND_PER_PHASE = 50;
  localparam int HOLD_CYCLES    = 200;
  localparam int LAT_PAD        = 8;

  localparam src_fmt_t PHASE_FMT [NUM_PHASES] = '{
    SRC_RGB_U8, SRC_RGB_U8, SRC_RGB_U16, SRC_RGB_F16, SRC_RGB_F32,
    SRC_RGBA_U8, SRC_RGBA_U16, SRC_RGBA_F16, SRC_RGBA_F32,
    SRC_RGB_F32, SRC_RGBA_F16, SRC_RGB_U16, SRC_RGB_F16
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [2:0]                 cfg_data = 3'd0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [p2r8_pkg::RAW_W-1:0] red_in = '0;
  logic [p2r8_pkg::RAW_W-1:0] green_in = '0;
  logic [p2r8_pkg::RAW_W-1:0] blue_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [p2r8_pkg::PIX_W-1:0] red_out;
  logic [p2r8_pkg::PIX_W-1:0] green_out;
  logic [p2r8_pkg::PIX_W-1:0] blue_out;

  src_pixel_t pending_pixels [$];
  rgb8_t      rgb_expected [$];
  logic [2:0] fmt_model = 3'd0;
  logic       in_took = 1'b0;
  int         errors = 0;

  // knobs, written at rising edges, read by the falling-edge drivers
  bit quiet = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;

  // driver-private counters
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_served = 0;

  pixel_to_rgb8_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // value = sig * 2^ex; truncated product with 255, clamped to 0..255
  function automatic logic [p2r8_pkg::PIX_W-1:0] times255_clamped(
    logic [p2r8_pkg::SIG_W-1:0] sig, int ex);
    logic [63:0] p;
    p = 64'(sig) * 64'd255;
    if (p == 64'd0) return p2r8_pkg::PIX_ZERO;
    if (ex >= 0) begin
      if (ex >= 8) return p2r8_pkg::PIX_MAX;
      p = p << ex;
    end else begin
      if (-ex >= 64) return p2r8_pkg::PIX_ZERO;
      p = p >> (-ex);
    end
    return (p > 64'd255) ? p2r8_pkg::PIX_MAX : p[7:0];
  endfunction

  function automatic logic [p2r8_pkg::PIX_W-1:0] half_to_pix(logic [15:0] h);
    logic       sign;
    logic [4:0] ef;
    logic [9:0] fr;
    sign = h[15];
    ef   = h[14:10];
    fr   = h[9:0];
    if (ef == 5'h1F) return (fr != '0 || sign) ? p2r8_pkg::PIX_ZERO : p2r8_pkg::PIX_MAX;
    if (sign) return p2r8_pkg::PIX_ZERO;
    if (ef == 5'h00) return times255_clamped(p2r8_pkg::SIG_W'(fr), -24);
    return times255_clamped(p2r8_pkg::SIG_W'({1'b1, fr}), int'(ef) - 25);
  endfunction

  function automatic logic [p2r8_pkg::PIX_W-1:0] single_to_pix(logic [31:0] s);
    logic        sign;
    logic [7:0]  ef;
    logic [22:0] fr;
    sign = s[31];
    ef   = s[30:23];
    fr   = s[22:0];
    if (ef == 8'hFF) return (fr != '0 || sign) ? p2r8_pkg::PIX_ZERO : p2r8_pkg::PIX_MAX;
    if (sign) return p2r8_pkg::PIX_ZERO;
    if (ef == 8'h00) return times255_clamped(p2r8_pkg::SIG_W'(fr), -149);
    return times255_clamped({1'b1, fr}, int'(ef) - 150);
  endfunction

  function automatic logic [p2r8_pkg::PIX_W-1:0] channel_to_pix(
    logic [2:0] src, logic [p2r8_pkg::RAW_W-1:0] raw);
    case (p2r8_pkg::fmt_kind_t'(src[1:0]))
      p2r8_pkg::FMT_U8:  return raw[7:0];
      p2r8_pkg::FMT_U16: return raw[15:8];
      p2r8_pkg::FMT_F16: return half_to_pix(raw[15:0]);
      default:           return single_to_pix(raw);
    endcase
  endfunction

  function automatic rgb8_t convert_pixel(logic [2:0] src, src_pixel_t px);
    rgb8_t o;
    o.r = channel_to_pix(src, px.r);
    o.g = channel_to_pix(src, px.g);
    o.b = channel_to_pix(src, px.b);
    return o;
  endfunction

  // mostly values that land inside 0..255 after scaling, some specials, some noise
  function automatic logic [p2r8_pkg::RAW_W-1:0] rand_raw(logic [2:0] src);
    logic [p2r8_pkg::RAW_W-1:0] raw;
    int unsigned                pick;
    raw  = $urandom;
    pick = $urandom_range(99);
    case (p2r8_pkg::fmt_kind_t'(src[1:0]))
      p2r8_pkg::FMT_F16: begin
        if (pick < 60) begin
          raw[15]    = ($urandom_range(9) == 0);
          raw[14:10] = 5'($urandom_range(22, 6));
        end else if (pick < 75) begin
          raw[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
          if ($urandom_range(3) == 0) raw[9:0] = '0;
        end
      end
      p2r8_pkg::FMT_F32: begin
        if (pick < 60) begin
          raw[31]    = ($urandom_range(9) == 0);
          raw[30:23] = 8'($urandom_range(135, 110));
        end else if (pick < 75) begin
          raw[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
          if ($urandom_range(3) == 0) raw[22:0] = '0;
        end
      end
      default: begin
        if (pick < 15) raw[15:0] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      end
    endcase
    return raw;
  endfunction

  task automatic push_pixel(logic [p2r8_pkg::RAW_W-1:0] r, logic [p2r8_pkg::RAW_W-1:0] g,
                            logic [p2r8_pkg::RAW_W-1:0] b);
    src_pixel_t px;
    px.r = r;
    px.g = g;
    px.b = b;
    pending_pixels.push_back(px);
  endtask

  task automatic write_format(src_fmt_t src);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= src;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic check_field(string name, logic [p2r8_pkg::PIX_W-1:0] want,
                             logic [p2r8_pkg::PIX_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %02h actual %02h", $time, name, want, got);
    end
  endtask

  // source side
  always @(negedge clk) begin : drive_pixels
    src_pixel_t nxt;
    if (!rst && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(99) < send_idle_pct) begin
        send_gap = $urandom_range(14, 1) - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        nxt = pending_pixels.pop_front();
        red_in   <= nxt.r;
        green_in <= nxt.g;
        blue_in  <= nxt.b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk) begin : drive_sink
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < recv_idle_pct) begin
      recv_gap = $urandom_range(14, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // prediction on accepted inputs, comparison on accepted outputs
  always @(posedge clk) begin : score
    src_pixel_t px;
    rgb8_t      want;
    if (rst) begin
      fmt_model <= SRC_RGB_U8;
      in_took   <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_we) fmt_model <= cfg_data;
      if (in_valid && in_ready) begin
        px.r = red_in;
        px.g = green_in;
        px.b = blue_in;
        rgb_expected.push_back(convert_pixel(fmt_model, px));
      end
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          errors++;
          $display("%0t unexpected item: expected none actual %02h %02h %02h",
                   $time, red_out, green_out, blue_out);
        end else begin
          want = rgb_expected.pop_front();
          check_field("red", want.r, red_out);
          check_field("green", want.g, green_out);
          check_field("blue", want.b, blue_out);
        end
      end
    end
  end

  initial begin : main_flow
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // phase 0 runs on the reset value of the format register
      if (ph > 0) write_format(PHASE_FMT[ph]);
      @(posedge clk);
      quiet         = (ph == NUM_PHASES - 1);
      send_idle_pct = (ph % 4 == 2 || ph == HOLD_PHASE) ? 0 : $urandom_range(45, 5);
      recv_idle_pct = (ph % 4 == 1) ? 0 : $urandom_range(45, 5);
      if (ph == HOLD_PHASE) hold_asks++;
      case (ph)
        0: begin
          push_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
          push_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
        1: push_pixel(32'h1234_5680, 32'hABCD_EF7F, 32'h0000_007F);
        2: begin
          push_pixel(32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_00FF);
          push_pixel(32'h0000_00FF, 32'h0000_0100, 32'hABCD_8000);
        end
        3: begin
          push_pixel(32'h0000_3C00, 32'h0000_0000, 32'h0000_8000);  // one, +0, -0
          push_pixel(32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01);  // +inf, -inf, NaN
          push_pixel(32'h0000_03FF, 32'h0000_3BFF, 32'h0000_5BF8);  // subnormal, <1, 255.0
          push_pixel(32'h0000_BC00, 32'h0000_1C00, 32'hABCD_3800);
        end
        4: begin
          push_pixel(32'h3F80_0000, 32'h0000_0000, 32'h8000_0000);
          push_pixel(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000);
          push_pixel(32'h007F_FFFF, 32'h3F7F_FFFF, 32'h7F7F_FFFF);
          push_pixel(32'hBF80_0000, 32'h3B80_8081, 32'h437F_0000);
        end
        5: push_pixel(32'hFFFF_FF00, 32'h0000_00FF, 32'h5A5A_5AA5);
        6: push_pixel(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_8001);
        7: begin
          push_pixel(32'hFFFF_3C00, 32'h0000_7BFF, 32'h0000_FFFF);
          push_pixel(32'h0000_0001, 32'h0000_7C00, 32'h0000_3400);
        end
        8: begin
          push_pixel(32'h7F7F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
          push_pixel(32'h3F00_0000, 32'h7F80_0000, 32'h807F_FFFF);
        end
        default: ;
      endcase
      repeat (RAND_PER_PHASE)
        push_pixel(rand_raw(PHASE_FMT[ph]), rand_raw(PHASE_FMT[ph]), rand_raw(PHASE_FMT[ph]));
      while (pending_pixels.size() != 0 || in_valid || rgb_expected.size() != 0)
        @(negedge clk);
      repeat (LAT_PAD) @(negedge clk);
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
